>>> design/s3wf_pkg.sv
// ----------------------------------------------------------------------------
// s3wf_pkg
// Shared types and constants of the 3x3 weighted stencil filter.
// ----------------------------------------------------------------------------
package s3wf_pkg;

	localparam int PIX_W   = 16;
	localparam int DIM_W   = 11;
	localparam int WGT_W   = 16;
	localparam int POS_W   = 10;
	localparam int VAL_W   = 36;
	localparam int NSUM_W  = 19;
	localparam int PROD_A_W = WGT_W + NSUM_W;
	localparam int PROD_B_W = WGT_W + PIX_W;
	localparam int IDX_W   = 2;

	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int ODEPTH = 4;
	localparam int OCNT_W = $clog2(ODEPTH + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_NEIGHBOR_WEIGHT = 2'd2,
		REG_CENTER_WEIGHT   = 2'd3
	} reg_idx_t;

	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH     = 11'd800;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT    = 11'd800;
	localparam logic [WGT_W-1:0] RST_NEIGHBOR_WEIGHT = 16'd128;
	localparam logic [WGT_W-1:0] RST_CENTER_WEIGHT   = 16'd1280;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [WGT_W-1:0] neighbor_weight;
		logic [WGT_W-1:0] center_weight;
	} cfg_t;

	// One classified pixel on its way from the front to the back.
	typedef struct packed {
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [PIX_W-1:0]  pixel;
		logic              border;
		logic              interior;
		logic [NSUM_W-1:0] nsum;
		logic [PIX_W-1:0]  center;
	} qent_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             last;
	} res_t;

endpackage

>>> design/s3wf_ram.sv
// ----------------------------------------------------------------------------
// s3wf_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module s3wf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/s3wf_fifo.sv
// ----------------------------------------------------------------------------
// s3wf_fifo
// Small register FIFO with the head shown on rdata and a fill count.
// ----------------------------------------------------------------------------
module s3wf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		logic [AW-1:0] n;
		if (p == AW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + AW'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = mem_q[rd_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

>>> design/s3wf_front.sv
// ----------------------------------------------------------------------------
// s3wf_front
// Front end: takes pixels, keeps position, line stores and the 3x3 window,
// and hands classified pixels with their neighbor sums to the queue.
// ----------------------------------------------------------------------------
module s3wf_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  s3wf_pkg::cfg_t               cfg,
	input  logic                         push,
	input  logic [s3wf_pkg::PIX_W-1:0]   pixel,
	output logic                         full,
	input  logic [s3wf_pkg::QCNT_W-1:0]  q_count,
	output logic                         q_push,
	output s3wf_pkg::qent_t              q_data
);

	import s3wf_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int HEW = $clog2(MAX_HEIGHT + 1);

	logic [WEW-1:0] w_eff;
	logic [HEW-1:0] h_eff;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic           col_end;
	logic           row_end;
	logic           acc;

	logic                 valid_s1;
	logic [PIX_W-1:0]     px_s1;
	logic [CW-1:0]        col_s1;
	logic [POS_W-1:0]     rowp_s1;
	logic [POS_W-1:0]     colp_s1;
	logic                 border_s1;
	logic                 interior_s1;

	logic [2*PIX_W-1:0]   rd_data;
	logic [PIX_W-1:0]     top_v;
	logic [PIX_W-1:0]     mid_v;
	logic [PIX_W-1:0]     win_q [3][3];
	logic [PIX_W-1:0]     win_d [3][3];
	logic [NSUM_W-1:0]    nsum;

	always_comb begin
		if (cfg.image_width < DIM_W'(3)) begin
			w_eff = WEW'(3);
		end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = WEW'(cfg.image_width);
		end
		if (cfg.image_height < DIM_W'(3)) begin
			h_eff = HEW'(3);
		end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HEW'(MAX_HEIGHT);
		end else begin
			h_eff = HEW'(cfg.image_height);
		end
	end

	assign col_end = (WEW'(col_q) >= (w_eff - WEW'(1)));
	assign row_end = (HEW'(row_q) >= (h_eff - HEW'(1)));
	assign full    = ((32'(q_count) + 32'(valid_s1)) >= QDEPTH);
	assign acc     = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1       <= pixel;
			col_s1      <= col_q;
			rowp_s1     <= POS_W'(row_q);
			colp_s1     <= POS_W'(col_q);
			border_s1   <= (row_q == '0) || (col_q == '0) || col_end || row_end;
			interior_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
		end
	end

	// The upper store sits in the high half, the middle store in the low half.
	s3wf_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(col_s1),
		.wdata({mid_v, px_s1}),
		.re   (acc),
		.raddr(col_q),
		.rdata(rd_data)
	);

	assign top_v = rd_data[2*PIX_W-1:PIX_W];
	assign mid_v = rd_data[PIX_W-1:0];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r][0] = win_q[r][1];
			win_d[r][1] = win_q[r][2];
		end
		win_d[0][2] = top_v;
		win_d[1][2] = mid_v;
		win_d[2][2] = px_s1;
		nsum = NSUM_W'(win_d[0][0]) + NSUM_W'(win_d[0][1]) + NSUM_W'(win_d[0][2])
			+ NSUM_W'(win_d[1][0]) + NSUM_W'(win_d[1][2])
			+ NSUM_W'(win_d[2][0]) + NSUM_W'(win_d[2][1]) + NSUM_W'(win_d[2][2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (valid_s1) begin
			win_q <= win_d;
		end
	end

	assign q_push = valid_s1 & (border_s1 | interior_s1);

	always_comb begin
		q_data.row      = rowp_s1;
		q_data.col      = colp_s1;
		q_data.pixel    = px_s1;
		q_data.border   = border_s1;
		q_data.interior = interior_s1;
		q_data.nsum     = nsum;
		q_data.center   = win_d[1][1];
	end

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (32'(q_count) < QDEPTH))
		else $error("front pushed into a full queue");

	a_s1_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted pixel did not reach the window stage");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc && col_end |=> (col_q == '0))
		else $error("column did not wrap at the end of a row");

endmodule

>>> design/s3wf_back.sv
// ----------------------------------------------------------------------------
// s3wf_back
// Back end: expands queued pixels into border and interior results,
// multiplies by the weights and buffers the results for the consumer.
// ----------------------------------------------------------------------------
module s3wf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  s3wf_pkg::cfg_t              cfg,
	input  logic                        q_empty,
	input  s3wf_pkg::qent_t             q_data,
	output logic                        q_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [s3wf_pkg::POS_W-1:0]  out_row,
	output logic [s3wf_pkg::POS_W-1:0]  out_col,
	output logic [s3wf_pkg::VAL_W-1:0]  value,
	output logic                        last
);

	import s3wf_pkg::*;

	logic              phase_q;
	logic              room;
	logic              issue;
	logic              do_border;
	logic [OCNT_W-1:0] o_count;
	logic              o_pop;

	logic                valid_b1;
	logic [POS_W-1:0]    row_b1;
	logic [POS_W-1:0]    col_b1;
	logic                last_b1;
	logic [VAL_W-1:0]    prod_a_b1;
	logic [PROD_B_W-1:0] prod_b_b1;

	logic                valid_b2;
	res_t                res_b2;
	res_t                res_head;

	assign room  = ((32'(o_count) + 32'(valid_b1) + 32'(valid_b2)) < ODEPTH);
	assign issue = ~q_empty & room;
	assign do_border = q_data.border & ~phase_q;
	assign q_pop = issue & ~(do_border & q_data.interior);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
		end else begin
			valid_b1 <= issue;
			valid_b2 <= valid_b1;
			if (issue) begin
				phase_q <= do_border & q_data.interior;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (do_border) begin
				row_b1    <= q_data.row;
				col_b1    <= q_data.col;
				last_b1   <= ~q_data.interior;
				prod_a_b1 <= VAL_W'({q_data.pixel, 8'd0});
				prod_b_b1 <= '0;
			end else begin
				row_b1    <= q_data.row - POS_W'(1);
				col_b1    <= q_data.col - POS_W'(1);
				last_b1   <= 1'b1;
				prod_a_b1 <= VAL_W'(PROD_A_W'(cfg.neighbor_weight) * PROD_A_W'(q_data.nsum));
				prod_b_b1 <= PROD_B_W'(cfg.center_weight) * PROD_B_W'(q_data.center);
			end
		end
		if (valid_b1) begin
			res_b2.row   <= row_b1;
			res_b2.col   <= col_b1;
			res_b2.last  <= last_b1;
			res_b2.value <= prod_a_b1 + VAL_W'(prod_b_b1);
		end
	end

	assign o_pop = pop & ~empty;

	s3wf_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(ODEPTH)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_b2),
		.wdata (res_b2),
		.pop   (o_pop),
		.rdata (res_head),
		.empty (empty),
		.count (o_count)
	);

	assign out_row = res_head.row;
	assign out_col = res_head.col;
	assign value   = res_head.value;
	assign last    = res_head.last;

	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (q_data.border || q_data.interior))
		else $error("queued pixel carries no result");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_b2 |-> ((32'(o_count) < ODEPTH) || o_pop))
		else $error("result buffer overflow");

	a_phase_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!q_empty && q_data.border && q_data.interior))
		else $error("second result pending without a two-result pixel");

endmodule

>>> design/stencil_3x3_weighted_filter_top.sv
// ----------------------------------------------------------------------------
// stencil_3x3_weighted_filter_top
// 3x3 weighted stencil over a raster-order pixel stream with pass-through
// borders, built from a front end, a request queue and a multiply back end.
//
//   Channel   Handshake          Payload
//   input     push / full        pixel
//   result    empty / pop        out_row, out_col, value, last
//   config    cfg_we             cfg_index, cfg_data
//
// A pixel is taken every cycle while the request queue has room. The back end
// issues one result per cycle while the result buffer has room, so pixels with
// two results (last row, last column) hold the queue head for a second issue;
// the queue absorbs short bursts of them. Reset clears position and window
// and loads the reset configuration; the line stores are not cleared.
// ----------------------------------------------------------------------------
module stencil_3x3_weighted_filter_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [s3wf_pkg::PIX_W-1:0]  pixel,
	output logic                        empty,
	input  logic                        pop,
	output logic [s3wf_pkg::POS_W-1:0]  out_row,
	output logic [s3wf_pkg::POS_W-1:0]  out_col,
	output logic [s3wf_pkg::VAL_W-1:0]  value,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic [s3wf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [s3wf_pkg::WGT_W-1:0]  cfg_data
);

	import s3wf_pkg::*;

	cfg_t              cfg_q;
	logic              q_push;
	qent_t             q_wdata;
	logic              q_pop;
	qent_t             q_rdata;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= RST_IMAGE_WIDTH;
			cfg_q.image_height    <= RST_IMAGE_HEIGHT;
			cfg_q.neighbor_weight <= RST_NEIGHBOR_WEIGHT;
			cfg_q.center_weight   <= RST_CENTER_WEIGHT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data[DIM_W-1:0];
				REG_NEIGHBOR_WEIGHT: cfg_q.neighbor_weight <= cfg_data;
				REG_CENTER_WEIGHT:   cfg_q.center_weight   <= cfg_data;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	s3wf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.pixel  (pixel),
		.full   (full),
		.q_count(q_count),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	s3wf_fifo #(
		.WIDTH($bits(qent_t)),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.count (q_count)
	);

	s3wf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(q_empty),
		.q_data (q_rdata),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.out_row(out_row),
		.out_col(out_col),
		.value  (value),
		.last   (last)
	);

endmodule
